[rtl/core/pfe_pkg.sv]
package pfe_pkg;

   localparam int DATA_W              = 32;
   localparam int SYMBOL_W            = 8;
   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int DIV_STEPS           = DATA_W;
   localparam int STEP_W              = $clog2(DIV_STEPS);

   localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [SYMBOL_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [SYMBOL_W-1:0] CHAR_SLASH = 8'h2F;

   localparam logic [DATA_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     underflow;
      logic                     overflow;
      logic                     divide_by_zero;
   } rsp_type;

   typedef struct packed {
      logic underflow;
      logic overflow;
      logic divide_by_zero;
   } err_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_TAKE_PREV,
      CELL_TAKE_NEXT
   } cell_op_type;

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CALC,
      ST_DIV,
      ST_WRITE,
      ST_FINAL
   } state_type;

   function automatic op_type decode_op(input logic [SYMBOL_W-1:0] symbol);
      op_type op;
      case (symbol)
         CHAR_PLUS:  op = OP_ADD;
         CHAR_MINUS: op = OP_SUB;
         CHAR_STAR:  op = OP_MUL;
         CHAR_SLASH: op = OP_DIV;
         default:    op = OP_PUSH;
      endcase
      return op;
   endfunction

endpackage

[rtl/core/postfix_expression_evaluator.sv]
// Postfix expression evaluator.
// A request carries one character of a postfix expression and a last flag.
// Characters + - * / are operators; every other code pushes its value minus
// 48. An operator pops the right and then the left operand and pushes the
// 32-bit wrapped result; division truncates toward zero.
// After a request with last set, the top of the stack is popped and sent on
// the rsp channel together with the sticky underflow, overflow and
// divide-by-zero flags, which are then cleared. Other requests send nothing.
// Requests are taken one at a time; req_stall is high while one is at work.
// The quotient unit retires one quotient bit per cycle.
// A result reaches rsp in the cycle after the final pop and holds in the
// output register while rsp_stall is high; the next request may be accepted
// meanwhile, but another result waits until that one is taken.
// The stack is a row of cells, top entry in cell 0; push and pop shift the
// whole row by one place together.
// Reset empties the stack count, clears the flags and drops rsp_valid;
// no clearing pass is needed.
module postfix_expression_evaluator import pfe_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   err_type           err_ff, err_in;
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic              last_ff, last_in;
   op_type            opr_ff, opr_in;
   logic [DATA_W-1:0] left_ff, left_in;
   logic [DATA_W-1:0] right_ff, right_in;
   logic [DATA_W-1:0] res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept;
   cell_op_type       op_top;
   cell_op_type       op_rest;
   logic [DATA_W-1:0] load_data;
   logic              div_start;
   logic              div_done;
   logic [DATA_W-1:0] div_quotient;
   logic [DATA_W-1:0] cell_data [STACK_DEPTH];

   // stack cells: cell 0 is the top, loads come in through its prev port
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] prev_data;
      logic [DATA_W-1:0] next_data;
      cell_op_type       cell_op;
      if (i == 0) begin : g_top
         assign prev_data = load_data;
         assign cell_op   = op_top;
      end else begin : g_body
         assign prev_data = cell_data[i-1];
         assign cell_op   = op_rest;
      end
      if (i == STACK_DEPTH - 1) begin : g_end
         assign next_data = cell_data[i];
      end else begin : g_link
         assign next_data = cell_data[i+1];
      end
      pfe_cell u_cell (
         .clock     (clock),
         .op        (cell_op),
         .prev_data (prev_data),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   pfe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (left_ff),
      .divisor  (right_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      opr_in       = opr_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      op_top       = CELL_HOLD;
      op_rest      = CELL_HOLD;
      load_data    = res_ff;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sym_in   = req_data.symbol;
               last_in  = req_data.last;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            opr_in = decode_op(sym_ff);
            if (decode_op(sym_ff) == OP_PUSH) begin
               // push the operand, or drop it and flag overflow when full
               load_data = {{(DATA_W-SYMBOL_W){1'b0}}, sym_ff}
                         - {{(DATA_W-SYMBOL_W){1'b0}}, CHAR_ZERO};
               if (count_ff < CNT_W'(STACK_DEPTH)) begin
                  op_top   = CELL_TAKE_PREV;
                  op_rest  = CELL_TAKE_PREV;
                  count_in = count_ff + 1'b1;
               end else begin
                  err_in.overflow = 1'b1;
               end
               state_in = last_ff ? ST_FINAL : ST_IDLE;
            end else begin
               // read both operands; missing ones read as all ones
               right_in = (count_ff >= CNT_W'(1)) ? cell_data[0] : ALL_ONES;
               left_in  = (count_ff >= CNT_W'(2)) ? cell_data[1] : ALL_ONES;
               if (count_ff < CNT_W'(2)) begin
                  err_in.underflow = 1'b1;
               end
               state_in = ST_CALC;
            end
         end

         ST_CALC: begin
            state_in = ST_WRITE;
            case (opr_ff)
               OP_ADD: res_in = left_ff + right_ff;
               OP_SUB: res_in = left_ff - right_ff;
               OP_MUL: res_in = left_ff * right_ff;
               OP_DIV: begin
                  if (right_ff == '0) begin
                     res_in                = ALL_ONES;
                     err_in.divide_by_zero = 1'b1;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               default: res_in = left_ff;
            endcase
         end

         ST_DIV: begin
            if (div_done) begin
               res_in   = div_quotient;
               state_in = ST_WRITE;
            end
         end

         ST_WRITE: begin
            // two pops and one push: shift up one place and load the top,
            // or just load the top when the stack held fewer than two
            op_top = CELL_TAKE_PREV;
            if (count_ff >= CNT_W'(2)) begin
               op_rest  = CELL_TAKE_NEXT;
               count_in = count_ff - 1'b1;
            end else begin
               count_in = CNT_W'(1);
            end
            state_in = last_ff ? ST_FINAL : ST_IDLE;
         end

         ST_FINAL: begin
            // hold until the output register is free, then pop and send
            if (!rsp_valid_ff || !rsp_stall) begin
               if (count_ff != '0) begin
                  rsp_in.value     = cell_data[0];
                  rsp_in.underflow = err_ff.underflow;
                  op_top           = CELL_TAKE_NEXT;
                  op_rest          = CELL_TAKE_NEXT;
                  count_in         = count_ff - 1'b1;
               end else begin
                  rsp_in.value     = ALL_ONES;
                  rsp_in.underflow = 1'b1;
               end
               rsp_in.overflow       = err_ff.overflow;
               rsp_in.divide_by_zero = err_ff.divide_by_zero;
               rsp_valid_in          = 1'b1;
               err_in                = '0;
               state_in              = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff   <= sym_in;
      last_ff  <= last_in;
      opr_ff   <= opr_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // the count never runs past the row of cells
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count above depth");

   // a new result appears only out of the final pop
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(state_ff) == ST_FINAL)
      else $error("result without final pop");

   // flags are clear once a result has been issued
   a_flags_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL && state_in == ST_IDLE) |=> err_ff == '0)
      else $error("flags not cleared after result");

   // the quotient unit starts only for a division with a nonzero divisor
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (opr_ff == OP_DIV && right_ff != '0))
      else $error("divider started without division");

   // the quotient arrives only while it is awaited
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("quotient outside divide state");

endmodule

[rtl/core/pfe_cell.sv]
module pfe_cell import pfe_pkg::*; (
   input  logic              clock,
   input  cell_op_type       op,
   input  logic [DATA_W-1:0] prev_data,
   input  logic [DATA_W-1:0] next_data,
   output logic [DATA_W-1:0] data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // take from the cell above on push, from the cell below on pop
   always_comb begin
      case (op)
         CELL_TAKE_PREV: data_in = prev_data;
         CELL_TAKE_NEXT: data_in = next_data;
         default:        data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[rtl/core/pfe_div.sv]
module pfe_div import pfe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;
   logic              last_step;

   // one restoring step per cycle on the magnitudes
   always_comb begin
      shifted   = {rem_ff, quo_ff[DATA_W-1]};
      trial     = shifted - {1'b0, dvs_ff};
      last_step = (step_ff == STEP_W'(DIV_STEPS - 1));
      busy_in   = busy_ff;
      step_in   = step_ff;
      done_in   = busy_ff && last_step;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
         rem_in = trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], ~trial[DATA_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

[bench/postfix_expression_evaluator_tb.sv]
`timescale 1ns / 1ps

module postfix_expression_evaluator_tb;
   import pfe_pkg::*;

   // Run shape
   localparam int RANDOM_REQUESTS = 700;
   localparam int CALM_TAIL       = 100;   // last requests run with no idling on either side
   localparam int PAUSE_AT        = 300;   // sender waits here until every result is back
   localparam int HOLD_AFTER      = 15;    // results checked before the long receiver hold
   localparam int LONG_HOLD       = 400;   // cycles of receiver hold-off
   localparam int IDLE_LIMIT      = 4000;  // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES   = 60;    // a division plus margin

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   postfix_expression_evaluator i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Evaluator state as the bench sees it
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] calc_stack [STACK_DEPTH_DEFAULT];
   int                calc_depth    = 0;
   err_type           sticky_errors = '0;

   req_type pending_requests[$];   // requests still to be offered
   rsp_type expected_results[$];   // results still to come, oldest first

   int mismatch_count = 0;

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // Map a character onto its operation; everything but + - * / is an operand.
   function automatic op_type symbol_op(input logic [SYMBOL_W-1:0] symbol);
      case (symbol)
         CHAR_PLUS:  return OP_ADD;
         CHAR_MINUS: return OP_SUB;
         CHAR_STAR:  return OP_MUL;
         CHAR_SLASH: return OP_DIV;
         default:    return OP_PUSH;
      endcase
   endfunction

   // Drop the value and flag overflow when the stack is full.
   function automatic void stack_push(input logic [DATA_W-1:0] operand);
      if (calc_depth >= STACK_DEPTH_DEFAULT) begin
         sticky_errors.overflow = 1'b1;
      end else begin
         calc_stack[calc_depth] = operand;
         calc_depth++;
      end
   endfunction

   // An empty stack yields all ones and flags underflow.
   function automatic logic [DATA_W-1:0] stack_pop();
      if (calc_depth == 0) begin
         sticky_errors.underflow = 1'b1;
         return ALL_ONES;
      end
      calc_depth--;
      return calc_stack[calc_depth];
   endfunction

   // Signed division rounded toward zero; the most negative value over -1 wraps.
   function automatic logic [DATA_W-1:0] quotient_toward_zero(input logic [DATA_W-1:0] dividend,
                                                              input logic [DATA_W-1:0] divisor);
      logic [DATA_W-1:0] mag_dividend, mag_divisor, mag_quotient;
      mag_dividend = dividend[DATA_W-1] ? -dividend : dividend;
      mag_divisor  = divisor[DATA_W-1] ? -divisor : divisor;
      mag_quotient = mag_dividend / mag_divisor;
      return (dividend[DATA_W-1] ^ divisor[DATA_W-1]) ? -mag_quotient : mag_quotient;
   endfunction

   // Apply one accepted request; queue a result when it closes an expression.
   task automatic evaluate_symbol(input req_type item);
      op_type            op;
      logic [DATA_W-1:0] right_val, left_val, outcome;
      rsp_type           result;
      op = symbol_op(item.symbol);
      if (op == OP_PUSH) begin
         stack_push(DATA_W'(item.symbol) - DATA_W'(CHAR_ZERO));
      end else begin
         // right operand sits on top
         right_val = stack_pop();
         left_val  = stack_pop();
         case (op)
            OP_ADD: outcome = left_val + right_val;
            OP_SUB: outcome = left_val - right_val;
            OP_MUL: outcome = left_val * right_val;
            default: begin
               if (right_val == '0) begin
                  sticky_errors.divide_by_zero = 1'b1;
                  outcome = ALL_ONES;
               end else begin
                  outcome = quotient_toward_zero(left_val, right_val);
               end
            end
         endcase
         stack_push(outcome);
      end
      if (item.last) begin
         // the final pop can raise underflow too, so read the flags after it
         result.value          = stack_pop();
         result.underflow      = sticky_errors.underflow;
         result.overflow       = sticky_errors.overflow;
         result.divide_by_zero = sticky_errors.divide_by_zero;
         expected_results.push_back(result);
         sticky_errors = '0;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------
   task automatic add_request(input logic [SYMBOL_W-1:0] symbol, input logic last);
      req_type item;
      item.symbol = symbol;
      item.last   = last;
      pending_requests.push_back(item);
   endtask

   // One expression from a string; the final character carries last.
   task automatic add_string(input string text);
      for (int i = 0; i < text.len(); i++)
         add_request(text[i], i == text.len() - 1);
   endtask

   function automatic logic [SYMBOL_W-1:0] random_operator();
      case ($urandom_range(0, 4))
         0:       return CHAR_PLUS;
         1:       return CHAR_MINUS;
         2:       return CHAR_STAR;
         default: return CHAR_SLASH;   // weight division: it is the long path
      endcase
   endfunction

   // Mostly decimal digits, sometimes any non-operator code.
   function automatic logic [SYMBOL_W-1:0] random_operand();
      logic [SYMBOL_W-1:0] symbol;
      if ($urandom_range(0, 4) != 0)
         return CHAR_ZERO + SYMBOL_W'($urandom_range(0, 9));
      do
         symbol = SYMBOL_W'($urandom_range(0, 255));
      while (symbol_op(symbol) != OP_PUSH);
      return symbol;
   endfunction

   // Well-formed postfix expression: operators only when two operands are up.
   task automatic add_expression(input int operand_total);
      int operands_left, operators_left, depth;
      logic [SYMBOL_W-1:0] symbol;
      operands_left  = operand_total;
      operators_left = operand_total - 1;
      depth          = 0;
      while (operands_left > 0 || operators_left > 0) begin
         if (depth >= 2 && operators_left > 0 &&
             (operands_left == 0 || $urandom_range(0, 1) == 1)) begin
            symbol = random_operator();
            operators_left--;
            depth--;
         end else begin
            symbol = random_operand();
            operands_left--;
            depth++;
         end
         add_request(symbol, operands_left == 0 && operators_left == 0);
      end
   endtask

   // Push past the top of the stack, then fold it back down with operators.
   task automatic add_stack_fill();
      for (int i = 0; i < STACK_DEPTH_DEFAULT + 6; i++)
         add_request(random_operand(), 1'b0);
      for (int i = 0; i < STACK_DEPTH_DEFAULT - 1; i++)
         add_request(random_operator(), i == STACK_DEPTH_DEFAULT - 2);
   endtask

   // ------------------------------------------------------------------
   // Driver: offer pending requests, hold a stalled one, idle in bursts
   // ------------------------------------------------------------------
   int      loaded_count = 0;
   int      send_gap     = 0;
   int      calm_from    = 0;
   bit      pause_done   = 1'b0;
   logic    calm_mode    = 1'b0;
   logic    offer;
   req_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            evaluate_symbol(req_data);
         // hold the payload while stalled; otherwise pick the next cycle's offer
         if (!(req_valid && req_stall)) begin
            offer = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (loaded_count == PAUSE_AT && !pause_done) begin
               // wait for every outstanding result before going on
               if (expected_results.size() == 0)
                  pause_done = 1'b1;
            end else if (pending_requests.size() > 0) begin
               if (!calm_mode && $urandom_range(0, 9) == 0) begin
                  send_gap = $urandom_range(0, 11);   // this cycle counts as the first
               end else begin
                  offer    = 1'b1;
                  next_req = pending_requests.pop_front();
                  loaded_count++;
               end
            end
            req_valid <= offer;
            if (offer)
               req_data <= next_req;
         end
         calm_mode <= (loaded_count >= calm_from);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each result, stall in bursts and once for a long stretch
   // ------------------------------------------------------------------
   int      checked_count  = 0;
   int      stall_gap      = 0;
   int      hold_left      = 0;
   bit      long_hold_done = 1'b0;
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with none expected: value %0d",
                                         rsp_data.value));
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.value !== want.value)
                  report_mismatch($sformatf("result %0d value: got %0d, want %0d",
                                            checked_count, rsp_data.value, want.value));
               if (rsp_data.underflow !== want.underflow)
                  report_mismatch($sformatf("result %0d underflow: got %b, want %b",
                                            checked_count, rsp_data.underflow, want.underflow));
               if (rsp_data.overflow !== want.overflow)
                  report_mismatch($sformatf("result %0d overflow: got %b, want %b",
                                            checked_count, rsp_data.overflow, want.overflow));
               if (rsp_data.divide_by_zero !== want.divide_by_zero)
                  report_mismatch($sformatf("result %0d divide_by_zero: got %b, want %b",
                                            checked_count, rsp_data.divide_by_zero,
                                            want.divide_by_zero));
               checked_count++;
            end
         end
         // once, hold off long enough for the block to back up into req_stall
         if (hold_left == 0 && !long_hold_done && checked_count >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
         end
         if (hold_left == 0 && stall_gap == 0 && !calm_mode && $urandom_range(0, 7) == 0)
            stall_gap = $urandom_range(1, 12);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: give up when no handshake happens for too long
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, expected_results.size());
         $display("FAIL postfix_expression_evaluator");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int directed_count;
      int fills_done;
      int pick;
      int noise_len;

      // Directed: code extremes as lone operands
      add_request(8'h00, 1'b1);
      add_request(8'hFF, 1'b1);
      // each operator; 64^5 * 2 wraps to the most negative value, then / -1 wraps
      add_string("34+");
      add_string("pp*p*p*p*2*01-/");
      // negative quotient truncates toward zero
      add_string("07-2/");
      // zero divisor
      add_string("50/");
      // operator on an empty stack: both pops underflow
      add_string("+");
      directed_count = pending_requests.size();

      // Random: mostly well-formed expressions, some noise and broken starts,
      // and two passes that push past the top of the stack
      fills_done = 0;
      while (pending_requests.size() < directed_count + RANDOM_REQUESTS) begin
         if (fills_done < 2 &&
             pending_requests.size() >= directed_count + 200 * (fills_done + 1)) begin
            add_stack_fill();
            fills_done++;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
               add_expression($urandom_range(1, 8));
            end else if (pick < 90) begin
               noise_len = $urandom_range(1, 6);
               for (int i = 0; i < noise_len; i++)
                  add_request(SYMBOL_W'($urandom_range(0, 255)), i == noise_len - 1);
            end else begin
               add_request(random_operator(), 1'b0);
               add_expression($urandom_range(1, 4));
            end
         end
      end
      calm_from = pending_requests.size() - CALM_TAIL;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // drain: every request taken and every result back
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("PASS postfix_expression_evaluator");
      else
         $display("FAIL postfix_expression_evaluator");
      $finish;
   end

endmodule
